// ===== src/uvs_pkg.sv =====
// ----------------------------------------------------------------------------
// uvs_pkg: shared types and constants of the uv sphere mesh generator
// Fixed-point angle constants, cordic arctangent table, state codes.
// ----------------------------------------------------------------------------
`default_nettype none

package uvs_pkg;

	// default sizing of the top level
	localparam int MAX_LAT_DEF      = 256;
	localparam int MAX_LON_DEF      = 256;
	localparam int CORDIC_STEPS_DEF = 16;

	// field widths
	localparam int CNT_W   = 9;
	localparam int IDX_W   = 17;
	localparam int POS_W   = 32;
	localparam int NRM_W   = 16;
	localparam int TEX_W   = 17;
	localparam int RAD_W   = 31;
	localparam int ANG_W   = 25;   // unsigned degrees q16.16 below 360
	localparam int ZW      = 26;   // signed residual angle
	localparam int CV_W    = 33;   // cordic x/y datapath
	localparam int NUM_W   = 34;   // divider numerator / quotient
	localparam int TDATA_W = 200;
	localparam int CFG_W   = 32;
	localparam int CFGA_W  = 3;

	// angles in degrees q16.16
	localparam logic [ANG_W-1:0] DEG_QUARTER = 25'd5898240;
	localparam logic [ANG_W-1:0] DEG_HALF    = 25'd11796480;
	localparam logic [ANG_W-1:0] DEG_THREE   = 25'd17694720;
	localparam logic [ANG_W-1:0] DEG_FULL    = 25'd23592960;
	localparam logic signed [CV_W-1:0] CORDIC_GAIN = 33'sd652032874;

	// configuration register indexes
	typedef enum logic [CFGA_W-1:0] {
		REG_LAT = 3'd0,
		REG_LON = 3'd1,
		REG_RAD = 3'd2,
		REG_CX  = 3'd3,
		REG_CY  = 3'd4,
		REG_CZ  = 3'd5
	} cfg_reg_t;

	// sequence phases
	typedef enum logic [1:0] {
		PH_RING = 2'd0,
		PH_POLE = 2'd1,
		PH_TRI  = 2'd2
	} phase_t;

	// arctangent of 2^-i in degrees q16.16
	function automatic logic signed [ZW-1:0] atan_deg(input logic [4:0] i);
		logic signed [ZW-1:0] r;
		case (i)
			5'd0:  r = 26'sd2949120;
			5'd1:  r = 26'sd1740967;
			5'd2:  r = 26'sd919879;
			5'd3:  r = 26'sd466945;
			5'd4:  r = 26'sd234379;
			5'd5:  r = 26'sd117304;
			5'd6:  r = 26'sd58666;
			5'd7:  r = 26'sd29335;
			5'd8:  r = 26'sd14668;
			5'd9:  r = 26'sd7334;
			5'd10: r = 26'sd3667;
			5'd11: r = 26'sd1833;
			5'd12: r = 26'sd917;
			5'd13: r = 26'sd458;
			5'd14: r = 26'sd229;
			5'd15: r = 26'sd115;
			5'd16: r = 26'sd57;
			5'd17: r = 26'sd29;
			5'd18: r = 26'sd14;
			5'd19: r = 26'sd7;
			5'd20: r = 26'sd4;
			5'd21: r = 26'sd2;
			5'd22: r = 26'sd1;
			default: r = 26'sd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== src/uvs_cordic.sv =====
// ----------------------------------------------------------------------------
// uvs_cordic: iterative rotation-mode cordic
// One micro-rotation per cycle; returns cos and sin in q2.30.
// ----------------------------------------------------------------------------
`default_nettype none

module uvs_cordic
	import uvs_pkg::*;
#(
	parameter int STEPS = CORDIC_STEPS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic [ANG_W-1:0]        ang,
	output logic                         done,
	output logic signed [POS_W-1:0]      cos_o,
	output logic signed [POS_W-1:0]      sin_o
);

	logic signed [CV_W-1:0] x_q, y_q;
	logic signed [ZW-1:0]   z_q;
	logic [4:0]             i_q;
	logic                   neg_q, busy_q, done_q;
	logic signed [CV_W-1:0] dx, dy;
	logic signed [ZW-1:0]   za;

	assign dx = y_q >>> i_q;
	assign dy = x_q >>> i_q;
	assign za = atan_deg(i_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			i_q    <= '0;
		end else if (busy_q) begin
			if (i_q == 5'(STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
			i_q <= i_q + 5'd1;
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= CORDIC_GAIN;
			y_q <= '0;
			// fold the angle into [-90, 90]
			if (ang <= DEG_QUARTER) begin
				z_q   <= ZW'(signed'({1'b0, ang}));
				neg_q <= 1'b0;
			end else if (ang <= DEG_THREE) begin
				z_q   <= ZW'(signed'({1'b0, ang})) - ZW'(signed'({1'b0, DEG_HALF}));
				neg_q <= 1'b1;
			end else begin
				z_q   <= ZW'(signed'({1'b0, ang})) - ZW'(signed'({1'b0, DEG_FULL}));
				neg_q <= 1'b0;
			end
		end else if (busy_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - za;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + za;
			end
		end
	end

	assign done  = done_q;
	assign cos_o = neg_q ? POS_W'(-x_q) : POS_W'(x_q);
	assign sin_o = neg_q ? POS_W'(-y_q) : POS_W'(y_q);

endmodule

`default_nettype wire

// ===== src/uvs_div.sv =====
// ----------------------------------------------------------------------------
// uvs_div: restoring divider
// One quotient bit per cycle, narrow divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module uvs_div
	import uvs_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [NUM_W-1:0]  num,
	input  wire logic [CNT_W-1:0]  den,
	output logic                   done,
	output logic [NUM_W-1:0]       quot
);

	logic [NUM_W-1:0] work_q;
	logic [CNT_W-1:0] rem_q, den_q;
	logic [5:0]       cnt_q;
	logic             busy_q, done_q;
	logic [CNT_W:0]   trial;
	logic             qbit;

	assign trial = {rem_q, work_q[NUM_W-1]};
	assign qbit  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= 6'(NUM_W);
		end else if (busy_q) begin
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
			cnt_q <= cnt_q - 6'd1;
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= num;
			rem_q  <= '0;
			den_q  <= den;
		end else if (busy_q) begin
			rem_q  <= qbit ? CNT_W'(trial - {1'b0, den_q}) : CNT_W'(trial);
			work_q <= {work_q[NUM_W-2:0], qbit};
		end
	end

	assign done = done_q;
	assign quot = work_q;

endmodule

`default_nettype wire

// ===== src/uvs_mul.sv =====
// ----------------------------------------------------------------------------
// uvs_mul: shared signed multiplier
// 32 x 32 signed product, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module uvs_mul
	import uvs_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      en,
	input  wire logic signed [POS_W-1:0]   a,
	input  wire logic signed [POS_W-1:0]   b,
	output logic signed [2*POS_W-1:0]      p_s1
);

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= a * b;
		end
	end

endmodule

`default_nettype wire

// ===== src/uv_sphere_mesh_generator.sv =====
// ----------------------------------------------------------------------------
// uv_sphere_mesh_generator: streams the vertices and triangles of a uv sphere
// A ring vertex passes through the four bit-serial divisions and the two cordic
// runs between input transfer and output valid; poles and triangles go from
// the checks straight to the done state.
// One item at a time: the input is ready again only once the item is loaded
// into the output register, which waits while the output is stalled.
// Reset restores the register defaults and starts at vertex 0.
// ----------------------------------------------------------------------------
`default_nettype none

module uv_sphere_mesh_generator
	import uvs_pkg::*;
#(
	parameter int MAX_LAT      = MAX_LAT_DEF,
	parameter int MAX_LON      = MAX_LON_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// configuration writes
	input  wire logic                cfg_wen,
	input  wire logic [CFGA_W-1:0]   cfg_idx,
	input  wire logic [CFG_W-1:0]    cfg_data,
	// input stream
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [7:0]          s_tdata,   // restart
	// output stream
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [TDATA_W-1:0]       m_tdata,   // item_index, field_a, field_b,
	                                            // field_c, normal_x, normal_y,
	                                            // normal_z, tex_u, tex_v
	output logic                     m_tuser,   // kind
	output logic                     m_tlast    // last
);

	// sequencer states
	typedef enum logic [14:0] {
		S_IDLE = 15'b000000000000001,
		S_CHK  = 15'b000000000000010,
		S_BR   = 15'b000000000000100,
		S_DIVA = 15'b000000000001000,
		S_CORA = 15'b000000000010000,
		S_DIVB = 15'b000000000100000,
		S_CORB = 15'b000000001000000,
		S_MNX  = 15'b000000010000000,
		S_MNZ  = 15'b000000100000000,
		S_MPX  = 15'b000001000000000,
		S_MPY  = 15'b000010000000000,
		S_MPZ  = 15'b000100000000000,
		S_DIVU = 15'b001000000000000,
		S_DIVV = 15'b010000000000000,
		S_DONE = 15'b100000000000000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [CNT_W-1:0]        lat_q, lon_q_cfg;
	logic [RAD_W-1:0]        rad_q;
	logic signed [POS_W-1:0] cx_q, cy_q, cz_q;

	// sequence counters
	phase_t           phase_q;
	logic [CNT_W-1:0] lon_q, lat_cnt_q;
	logic             sub_q;
	logic             restart_q;

	// vertex working values
	logic signed [POS_W-1:0] ca_q, sa_q, nx_q, nz_q;

	// staged result
	logic             stg_kind_q, stg_last_q;
	logic [IDX_W-1:0] stg_idx_q;
	logic [POS_W-1:0] stg_a_q, stg_b_q, stg_c_q;
	logic [NRM_W-1:0] stg_nx_q, stg_ny_q, stg_nz_q;
	logic [TEX_W-1:0] stg_u_q, stg_v_q;

	// clamped geometry
	logic [CNT_W-1:0]   nlat, nlon, lvl;
	logic [2*CNT_W-1:0] nv, prod_p, prod_c;
	logic [CNT_W-1:0]   lon_nx;
	logic               ok;
	logic               lat_end, lon_end;

	// shared units
	logic                    div_start, div_done;
	logic [NUM_W-1:0]        div_num, div_quot;
	logic [CNT_W-1:0]        div_den;
	logic                    cor_start, cor_done;
	logic signed [POS_W-1:0] cor_c, cor_s;
	logic                    mul_en;
	logic signed [POS_W-1:0] mul_a, mul_b;
	logic signed [2*POS_W-1:0] mul_p;
	logic signed [NUM_W-1:0] mul_r;
	logic                    out_free;

	// round half up of a q60 product down to q30
	function automatic logic signed [NUM_W-1:0] rnd30(input logic signed [2*POS_W-1:0] p);
		logic signed [2*POS_W-1:0] t;
		t = p + (64'sd1 <<< 29);
		return NUM_W'(t >>> 30);
	endfunction

	function automatic logic [POS_W-1:0] sat32(input logic signed [NUM_W:0] v);
		logic [POS_W-1:0] r;
		if (v > 35'sd2147483647) r = 32'h7FFF_FFFF;
		else if (v < -35'sd2147483648) r = 32'h8000_0000;
		else r = POS_W'(v);
		return r;
	endfunction

	function automatic logic [NRM_W-1:0] to_q15(input logic signed [POS_W-1:0] n);
		logic signed [POS_W:0] t;
		t = (POS_W+1)'(n) + 33'sd16384;
		t = t >>> 15;
		if (t > 33'sd32767) return 16'h7FFF;
		else if (t < -33'sd32768) return 16'h8000;
		else return NRM_W'(t);
	endfunction

	// center plus offset, saturated
	function automatic logic [POS_W-1:0] place(input logic signed [POS_W-1:0] c,
		input logic signed [NUM_W-1:0] m);
		return sat32((NUM_W+1)'(c) + (NUM_W+1)'(m));
	endfunction

	// division counts clamped to their legal range
	always_comb begin
		if (lat_q < 9'd2) nlat = 9'd2;
		else if (32'(lat_q) > MAX_LAT) nlat = CNT_W'(MAX_LAT);
		else nlat = lat_q;
		if (lon_q_cfg < 9'd3) nlon = 9'd3;
		else if (32'(lon_q_cfg) > MAX_LON) nlon = CNT_W'(MAX_LON);
		else nlon = lon_q_cfg;
	end

	assign lvl     = nlat - 9'd1;
	assign nv      = 18'(nlon) * 18'(lvl) + 18'd2;
	assign lat_end = lat_cnt_q == lvl - 9'd1;
	assign lon_end = lon_q == nlon - 9'd1;
	assign lon_nx  = lon_end ? 9'd0 : lon_q + 9'd1;
	assign prod_p  = 18'(lon_q) * 18'(lvl);
	assign prod_c  = 18'(lon_nx) * 18'(lvl);

	// counters still inside the current configuration
	always_comb begin
		case (phase_q)
			PH_RING, PH_TRI: ok = lon_q < nlon && lat_cnt_q < lvl;
			PH_POLE:         ok = lat_cnt_q < 9'd2;
			default:         ok = 1'b0;
		endcase
	end

	// divider operand selection: ring angles, then uv
	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = nlat;
		case (state_q)
			S_BR: begin
				div_start = phase_q == PH_RING;
				div_num   = NUM_W'(DEG_HALF) * NUM_W'(lat_cnt_q + 9'd1) + NUM_W'(nlat >> 1);
				div_den   = nlat;
			end
			S_CORA: begin
				div_start = cor_done;
				div_num   = NUM_W'(DEG_FULL) * NUM_W'(lon_q) + NUM_W'(nlon >> 1);
				div_den   = nlon;
			end
			S_MPZ: begin
				div_start = 1'b1;
				div_num   = (NUM_W'(lon_q) << 16) + NUM_W'((nlon - 9'd1) >> 1);
				div_den   = nlon - 9'd1;
			end
			S_DIVU: begin
				div_start = div_done;
				div_num   = (NUM_W'(lat_cnt_q + 9'd1) << 16) + NUM_W'(nlat >> 1);
				div_den   = nlat;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	assign cor_start = (state_q == S_DIVA || state_q == S_DIVB) && div_done;

	// multiplier operand selection, one product per cycle
	always_comb begin
		mul_en = 1'b1;
		mul_a  = signed'({1'b0, rad_q});
		mul_b  = '0;
		case (state_q)
			S_MNX: begin
				mul_a = sa_q;
				mul_b = cor_c;
			end
			S_MNZ: begin
				mul_a = sa_q;
				mul_b = cor_s;
			end
			S_MPX: mul_b = nx_q;
			S_MPY: mul_b = ca_q;
			S_MPZ: mul_b = nz_q;
			default: mul_en = 1'b0;
		endcase
	end

	assign mul_r = rnd30(mul_p);

	uvs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	uvs_cordic #(
		.STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.ang    (div_quot[ANG_W-1:0]),
		.done   (cor_done),
		.cos_o  (cor_c),
		.sin_o  (cor_s)
	);

	uvs_mul u_mul (
		.clk  (clk),
		.en   (mul_en),
		.a    (mul_a),
		.b    (mul_b),
		.p_s1 (mul_p)
	);

	assign s_tready = state_q == S_IDLE;
	assign out_free = !m_tvalid || m_tready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_q     <= 9'd8;
			lon_q_cfg <= 9'd8;
			rad_q     <= 31'd65536;
			cx_q      <= '0;
			cy_q      <= '0;
			cz_q      <= '0;
		end else if (cfg_wen) begin
			case (cfg_idx)
				REG_LAT: lat_q     <= cfg_data[CNT_W-1:0];
				REG_LON: lon_q_cfg <= cfg_data[CNT_W-1:0];
				REG_RAD: rad_q     <= cfg_data[RAD_W-1:0];
				REG_CX:  cx_q      <= signed'(cfg_data);
				REG_CY:  cy_q      <= signed'(cfg_data);
				REG_CZ:  cz_q      <= signed'(cfg_data);
				default: ;
			endcase
		end
	end

	// sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			phase_q   <= PH_RING;
			lon_q     <= '0;
			lat_cnt_q <= '0;
			sub_q     <= 1'b0;
			restart_q <= 1'b0;
			m_tvalid  <= 1'b0;
		end else begin
			// a transfer in the done state is refilled below
			if (m_tvalid && m_tready && state_q != S_DONE) m_tvalid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						restart_q <= s_tdata[0];
						state_q   <= S_CHK;
					end
				end
				// a restart or stale counters start over at vertex 0
				S_CHK: begin
					if (restart_q || !ok) begin
						phase_q   <= PH_RING;
						lon_q     <= '0;
						lat_cnt_q <= '0;
						sub_q     <= 1'b0;
					end
					state_q <= S_BR;
				end
				S_BR:   state_q <= (phase_q == PH_RING) ? S_DIVA : S_DONE;
				S_DIVA: if (div_done) state_q <= S_CORA;
				S_CORA: if (cor_done) state_q <= S_DIVB;
				S_DIVB: if (div_done) state_q <= S_CORB;
				S_CORB: if (cor_done) state_q <= S_MNX;
				S_MNX:  state_q <= S_MNZ;
				S_MNZ:  state_q <= S_MPX;
				S_MPX:  state_q <= S_MPY;
				S_MPY:  state_q <= S_MPZ;
				S_MPZ:  state_q <= S_DIVU;
				S_DIVU: if (div_done) state_q <= S_DIVV;
				S_DIVV: if (div_done) state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						m_tvalid <= 1'b1;
						state_q  <= S_IDLE;
						// step to the next element
						case (phase_q)
							PH_RING: begin
								if (lat_end) begin
									lat_cnt_q <= '0;
									if (lon_end) begin
										lon_q   <= '0;
										phase_q <= PH_POLE;
									end else begin
										lon_q <= lon_q + 9'd1;
									end
								end else begin
									lat_cnt_q <= lat_cnt_q + 9'd1;
								end
							end
							PH_POLE: begin
								if (lat_cnt_q == 9'd1) begin
									lat_cnt_q <= '0;
									phase_q   <= PH_TRI;
									sub_q     <= 1'b0;
								end else begin
									lat_cnt_q <= 9'd1;
								end
							end
							default: begin
								sub_q <= !sub_q;
								if (sub_q) begin
									if (lat_end) begin
										lat_cnt_q <= '0;
										if (lon_end) begin
											lon_q   <= '0;
											phase_q <= PH_RING;
										end else begin
											lon_q <= lon_q + 9'd1;
										end
									end else begin
										lat_cnt_q <= lat_cnt_q + 9'd1;
									end
								end
							end
						endcase
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath: staged result and output register
	always_ff @(posedge clk) begin
		case (state_q)
			S_BR: begin
				case (phase_q)
					PH_RING: begin
						stg_kind_q <= 1'b0;
						stg_last_q <= 1'b0;
						stg_idx_q  <= IDX_W'(prod_p + 18'(lat_cnt_q));
					end
					PH_POLE: begin
						stg_kind_q <= 1'b0;
						stg_last_q <= 1'b0;
						stg_a_q    <= cx_q;
						stg_c_q    <= cz_q;
						stg_nx_q   <= '0;
						stg_nz_q   <= '0;
						stg_u_q    <= 17'd32768;
						if (lat_cnt_q == 9'd1) begin
							stg_idx_q <= IDX_W'(nv - 18'd1);
							stg_b_q   <= sat32((NUM_W+1)'(cy_q) - (NUM_W+1)'(rad_q));
							stg_ny_q  <= 16'h8000;
							stg_v_q   <= 17'd65536;
						end else begin
							stg_idx_q <= IDX_W'(nv - 18'd2);
							stg_b_q   <= sat32((NUM_W+1)'(cy_q) + (NUM_W+1)'(rad_q));
							stg_ny_q  <= 16'h7FFF;
							stg_v_q   <= '0;
						end
					end
					default: begin
						stg_kind_q <= 1'b1;
						stg_last_q <= sub_q && lat_end && lon_end;
						stg_idx_q  <= IDX_W'({prod_p, 1'b0} + {lat_cnt_q, 1'b0} + 19'(sub_q));
						stg_nx_q   <= '0;
						stg_ny_q   <= '0;
						stg_nz_q   <= '0;
						stg_u_q    <= '0;
						stg_v_q    <= '0;
						if (lat_cnt_q == 9'd0) begin
							// pole caps
							if (!sub_q) begin
								stg_a_q <= POS_W'(nv - 18'd2);
								stg_b_q <= POS_W'(prod_c);
								stg_c_q <= POS_W'(prod_p);
							end else begin
								stg_a_q <= POS_W'(nv - 18'd1);
								stg_b_q <= POS_W'(prod_p + 18'(lvl) - 18'd1);
								stg_c_q <= POS_W'(prod_c + 18'(lvl) - 18'd1);
							end
						end else if (!sub_q) begin
							stg_a_q <= POS_W'(prod_p + 18'(lat_cnt_q) - 18'd1);
							stg_b_q <= POS_W'(prod_c + 18'(lat_cnt_q));
							stg_c_q <= POS_W'(prod_p + 18'(lat_cnt_q));
						end else begin
							stg_a_q <= POS_W'(prod_p + 18'(lat_cnt_q) - 18'd1);
							stg_b_q <= POS_W'(prod_c + 18'(lat_cnt_q) - 18'd1);
							stg_c_q <= POS_W'(prod_c + 18'(lat_cnt_q));
						end
					end
				endcase
			end
			S_CORA: begin
				if (cor_done) begin
					ca_q <= cor_c;
					sa_q <= cor_s;
				end
			end
			S_MNZ: nx_q <= POS_W'(mul_r);
			S_MPX: nz_q <= POS_W'(mul_r);
			S_MPY: begin
				stg_a_q  <= place(cx_q, mul_r);
				stg_nx_q <= to_q15(nx_q);
				stg_ny_q <= to_q15(ca_q);
				stg_nz_q <= to_q15(nz_q);
			end
			S_MPZ: stg_b_q <= place(cy_q, mul_r);
			S_DIVU: begin
				stg_c_q <= place(cz_q, mul_r);
				if (div_done) stg_u_q <= div_quot[TEX_W-1:0];
			end
			S_DIVV: if (div_done) stg_v_q <= div_quot[TEX_W-1:0];
			S_DONE: begin
				if (out_free) begin
					m_tdata <= {5'd0, stg_v_q, stg_u_q, stg_nz_q, stg_ny_q, stg_nx_q,
						stg_c_q, stg_b_q, stg_a_q, stg_idx_q};
					m_tuser <= stg_kind_q;
					m_tlast <= stg_last_q;
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire
